FILE: rtl/core/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding-window minimum filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int MAX_LINE   = 4096;

  localparam int PIX_W   = 8;
  localparam int POS_W   = 12;
  localparam int WSIZE_W = 6;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [WSIZE_W-1:0] wsize_t;

  localparam wsize_t WSIZE_RESET = wsize_t'(3);
  localparam pix_t   PIX_MAX     = '1;

endpackage

FILE: rtl/core/swmf_intf.sv
// ----------------------------------------------------------------------------
// swmf interfaces
// Valid/ready channels for pixels, results and the window size register.
// ----------------------------------------------------------------------------
interface swmf_px_if;
  logic          valid;
  logic          ready;
  swmf_pkg::pix_t pixel_in;
  logic          end_of_line;

  modport source (output valid, output pixel_in, output end_of_line, input ready);
  modport sink   (input valid, input pixel_in, input end_of_line, output ready);
endinterface

interface swmf_res_if;
  logic           valid;
  logic           ready;
  swmf_pkg::pix_t min_value;
  swmf_pkg::pos_t position;
  logic           last_of_line;

  modport source (output valid, output min_value, output position, output last_of_line,
                  input ready);
  modport sink   (input valid, input min_value, input position, input last_of_line,
                  output ready);
endinterface

interface swmf_cfg_if;
  logic             valid;
  logic             ready;
  swmf_pkg::wsize_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

FILE: rtl/core/swmf_cell.sv
// ----------------------------------------------------------------------------
// swmf_cell
// One cell of the minimum chain: holds the minimum of the last k+1 pixels.
// ----------------------------------------------------------------------------
module swmf_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  swmf_pkg::pix_t pix_i,
  input  swmf_pkg::pix_t prev_i,
  output swmf_pkg::pix_t min_d_o,
  output swmf_pkg::pix_t min_q_o
);

  swmf_pkg::pix_t min_d;
  swmf_pkg::pix_t min_q;

  // new pixel joins the window held by the left neighbor
  assign min_d = (pix_i < prev_i) ? pix_i : prev_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      min_q <= min_d;
    end
  end

  assign min_d_o = min_d;
  assign min_q_o = min_q;

endmodule

FILE: rtl/core/sliding_window_min_filter.sv
// ----------------------------------------------------------------------------
// sliding_window_min_filter
// 1-D grey-level erosion: minimum over a sliding window along an image line.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns each full window's minimum in the next
// cycle from an output register, at position window start plus half the
// window. A row of MaxWindow cells keeps, in cell k, the minimum of the last
// k+1 pixels; every accepted pixel updates all the cells at once, and the
// window size picks the cell that is read. The input stalls only while the
// output register holds a result that is not being taken. Partial windows
// give no result, pixels past MaxLine are dropped until end of line, and a
// window size write restarts the current line.
module sliding_window_min_filter #(
  parameter int MaxWindow = swmf_pkg::MAX_WINDOW,
  parameter int MaxLine   = swmf_pkg::MAX_LINE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swmf_cfg_if.sink   cfg_i,
  swmf_px_if.sink    px_i,
  swmf_res_if.source res_o
);

  localparam int CntW = $clog2(MaxLine + 1);
  localparam int WinW = $clog2(MaxWindow + 1);
  localparam int Cw0  = (CntW > WinW) ? CntW : WinW;
  localparam int CmpW = (Cw0 > swmf_pkg::WSIZE_W) ? Cw0 : swmf_pkg::WSIZE_W;
  localparam int IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int PosW = swmf_pkg::POS_W;

  swmf_pkg::wsize_t ws_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  swmf_pkg::pix_t   res_min_q;
  swmf_pkg::pos_t   res_pos_q;
  logic             res_last_q;

  logic [CmpW-1:0]      ws_ext, eff, cnt_ext, cnt_next_ext, pos_full;
  logic [PosW+CmpW-1:0] pos_ext;
  logic [IdxW-1:0]      sel;
  logic                 accept, cfg_wr, in_line, emit;

  swmf_pkg::pix_t cell_d [MaxWindow];
  swmf_pkg::pix_t cell_q [MaxWindow];

  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= swmf_pkg::WSIZE_RESET;
    end else if (cfg_wr) begin
      ws_q <= cfg_i.window_size;
    end
  end

  // zero acts as one, large sizes clip to the row length
  assign ws_ext = CmpW'(ws_q);
  always_comb begin
    if (ws_ext == '0) begin
      eff = CmpW'(1);
    end else if (ws_ext > CmpW'(MaxWindow)) begin
      eff = CmpW'(MaxWindow);
    end else begin
      eff = ws_ext;
    end
  end
  assign sel = IdxW'(eff - CmpW'(1));

  assign px_i.ready   = !res_valid_q || res_o.ready;
  assign accept       = px_i.valid && px_i.ready;
  assign cnt_ext      = CmpW'(cnt_q);
  assign in_line      = cnt_ext < CmpW'(MaxLine);
  assign cnt_next_ext = cnt_ext + CmpW'(1);
  assign emit         = in_line && (cnt_next_ext >= eff);
  assign pos_full     = cnt_next_ext - eff + (eff >> 1);
  assign pos_ext      = {{PosW{1'b0}}, pos_full};

  // row of cells, the first one sees an all-ones neighbor
  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    swmf_pkg::pix_t prev;
    if (k == 0) begin : g_head
      assign prev = swmf_pkg::PIX_MAX;
    end else begin : g_link
      assign prev = cell_q[k-1];
    end
    swmf_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (accept && in_line),
      .pix_i   (px_i.pixel_in),
      .prev_i  (prev),
      .min_d_o (cell_d[k]),
      .min_q_o (cell_q[k])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_wr) begin
      cnt_d = '0;
    end else if (accept) begin
      if (px_i.end_of_line) begin
        cnt_d = '0;
      end else if (in_line) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (accept) begin
      res_valid_d = emit;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_min_q  <= cell_d[sel];
      res_pos_q  <= pos_ext[PosW-1:0];
      res_last_q <= px_i.end_of_line;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.min_value    = res_min_q;
  assign res_o.position     = res_pos_q;
  assign res_o.last_of_line = res_last_q;

endmodule

FILE: rtl/core/swmf_checker.sv
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks of the sliding-window minimum filter.
// ----------------------------------------------------------------------------
module swmf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           px_valid_i,
  input logic           px_ready_i,
  input swmf_pkg::pix_t pixel_in_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input swmf_pkg::pix_t min_value_i,
  input swmf_pkg::pos_t position_i,
  input logic           last_of_line_i
);

  // a stalled result keeps its request
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(min_value_i)
      && $stable(position_i) && $stable(last_of_line_i))
    else $error("result changed while stalled");

  // the window holds the newest pixel
  a_min_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_valid_i && px_ready_i |=> !res_valid_i || (min_value_i <= $past(pixel_in_i)))
    else $error("window minimum above newest pixel");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> px_ready_i)
    else $error("input stalled with empty output register");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(px_valid_i && px_ready_i))
    else $error("result without a pixel request");

endmodule

bind sliding_window_min_filter swmf_checker u_swmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .px_valid_i     (px_i.valid),
  .px_ready_i     (px_i.ready),
  .pixel_in_i     (px_i.pixel_in),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .min_value_i    (res_o.min_value),
  .position_i     (res_o.position),
  .last_of_line_i (res_o.last_of_line)
);
